FILE: src/rrr_arm_forward_kinematics_core_assert.svh
// assertion macros shared by the checker
`ifndef RRR_ARM_FORWARD_KINEMATICS_CORE_ASSERT_SVH
`define RRR_ARM_FORWARD_KINEMATICS_CORE_ASSERT_SVH
// checked property, quiet while reset is high
`define RRRFK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
// checked property, also during reset
`define RRRFK_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

FILE: src/rrrfk_pkg.sv
// ----------------------------------------------------------------------------
// rrrfk_pkg
// shared types, constants and the arctangent table of the cordic chain
// ----------------------------------------------------------------------------
package rrrfk_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int TABLE_LEN         = 24;
  localparam int LEN_W             = 16;
  localparam int POS_W             = 19;
  localparam int CV_W              = 34;

  localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
  localparam logic [1:0] REG_UPPER_LINK  = 2'd1;
  localparam logic [1:0] REG_LOWER_LINK  = 2'd2;

  // one rotation lane: vector and residual angle
  typedef struct packed {
    logic signed [CV_W-1:0] x;
    logic signed [CV_W-1:0] y;
    logic signed [CV_W-1:0] z;
  } lane_t;

  // three lanes: base, shoulder, shoulder plus elbow
  typedef struct packed {
    lane_t [2:0] lane;
    logic  [2:0] flip;
  } cell_data_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [31:0] atan_angle(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: src/rrrfk_cordic_cell.sv
// ----------------------------------------------------------------------------
// rrrfk_cordic_cell
// one micro-rotation of the cordic chain, applied to all three lanes
// ----------------------------------------------------------------------------
module rrrfk_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid_in,
  input  rrrfk_pkg::cell_data_t d_in,
  output logic                 valid_out,
  output rrrfk_pkg::cell_data_t d_out
);
  import rrrfk_pkg::*;

  localparam logic signed [CV_W-1:0] ATAN = CV_W'(atan_angle(STAGE));

  cell_data_t d_next;

  // rotate towards zero residual
  always_comb begin
    d_next = d_in;
    for (int l = 0; l < 3; l++) begin
      if (d_in.lane[l].z < 0) begin
        d_next.lane[l].x = d_in.lane[l].x + (d_in.lane[l].y >>> STAGE);
        d_next.lane[l].y = d_in.lane[l].y - (d_in.lane[l].x >>> STAGE);
        d_next.lane[l].z = d_in.lane[l].z + ATAN;
      end else begin
        d_next.lane[l].x = d_in.lane[l].x - (d_in.lane[l].y >>> STAGE);
        d_next.lane[l].y = d_in.lane[l].y + (d_in.lane[l].x >>> STAGE);
        d_next.lane[l].z = d_in.lane[l].z - ATAN;
      end
    end
  end

  // hand on to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: src/rrr_arm_forward_kinematics_core.sv
// ----------------------------------------------------------------------------
// rrr_arm_forward_kinematics_core
// joint angles to end-effector position through a chain of cordic cells
// ----------------------------------------------------------------------------
// path: input register, then the cordic cells, then the registered arithmetic tail to the output word
// throughput: one word per cycle; the whole pipeline holds while a finished
// output word is stalled, the cordic chain sets the depth
// reset: valid bits clear, lengths return to 1.0 (4096)
module rrr_arm_forward_kinematics_core #(
  parameter int ANGLE_BITS    = rrrfk_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = rrrfk_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] base_angle,
  input  logic [15:0] shoulder_angle,
  input  logic [15:0] elbow_angle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [18:0] pos_x,
  output logic signed [18:0] pos_y,
  output logic signed [18:0] pos_z,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rrrfk_pkg::*;

  localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
  localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
  localparam logic signed [CV_W-1:0] GAIN = CV_W'(652032874);

  logic [LEN_W-1:0] base_height, upper_link_length, lower_link_length;
  logic adv;

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      base_height       <= 16'd4096;
      upper_link_length <= 16'd4096;
      lower_link_length <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BASE_HEIGHT: base_height       <= cfg_data;
        REG_UPPER_LINK:  upper_link_length <= cfg_data;
        REG_LOWER_LINK:  lower_link_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves unless a finished word is held
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // scale to 32-bit turns and fold into the right half plane
  logic [31:0] turn [3];
  cell_data_t  pre;
  always_comb begin
    logic [31:0] t2, f;
    turn[0] = ({16'd0, base_angle} & ANG_MASK) << (32 - ANGLE_BITS);
    t2      = ({16'd0, shoulder_angle} & ANG_MASK) << (32 - ANGLE_BITS);
    turn[1] = t2;
    turn[2] = t2 + (({16'd0, elbow_angle} & ANG_MASK) << (32 - ANGLE_BITS));
    for (int l = 0; l < 3; l++) begin
      pre.flip[l] = turn[l][31] ^ turn[l][30];
      f = pre.flip[l] ? turn[l] + 32'h8000_0000 : turn[l];
      pre.lane[l].x = GAIN;
      pre.lane[l].y = '0;
      pre.lane[l].z = {{(CV_W-32){f[31]}}, f};
    end
  end

  // cordic chain
  cell_data_t chain_d [NS+1];
  logic       chain_v [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_v[0] <= 1'b0;
    end else if (adv) begin
      chain_v[0] <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      chain_d[0] <= pre;
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_cell
    rrrfk_cordic_cell #(.STAGE(s)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .valid_in (chain_v[s]),
      .d_in     (chain_d[s]),
      .valid_out(chain_v[s+1]),
      .d_out    (chain_d[s+1])
    );
  end

  // undo the fold and round sine and cosine to 16 fraction bits
  logic signed [17:0] cs [3];
  logic signed [17:0] sn [3];
  logic signed [17:0] cs_r [3];
  logic signed [17:0] sn_r [3];
  logic v1, v2, v3, v4;
  always_comb begin
    logic signed [CV_W-1:0] xf, yf;
    for (int l = 0; l < 3; l++) begin
      xf = chain_d[NS].flip[l] ? -chain_d[NS].lane[l].x : chain_d[NS].lane[l].x;
      yf = chain_d[NS].flip[l] ? -chain_d[NS].lane[l].y : chain_d[NS].lane[l].y;
      cs[l] = 18'((xf + CV_W'(8192)) >>> 14);
      sn[l] = 18'((yf + CV_W'(8192)) >>> 14);
    end
  end

  // valid bits of the arithmetic tail
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= chain_v[NS];
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  // link products, then sums, then base products, then round and clip
  logic signed [34:0] p_c2, p_c23, p_s2, p_s23;
  logic signed [17:0] c1_2, s1_2, c1_3, s1_3;
  logic signed [35:0] a_sum;
  logic signed [20:0] z_3, z_4;
  logic signed [53:0] px, py;

  function automatic logic signed [18:0] clip(input logic signed [21:0] v);
    if (v < -22'sd262144) return -19'sd262144;
    if (v > 22'sd262143)  return 19'sd262143;
    return v[18:0];
  endfunction

  always_ff @(posedge clk) begin
    logic signed [36:0] zs;
    logic signed [21:0] xr, yr;
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        cs_r[l] <= cs[l];
        sn_r[l] <= sn[l];
      end
      p_c2  <= $signed({1'b0, upper_link_length}) * cs_r[1];
      p_c23 <= $signed({1'b0, lower_link_length}) * cs_r[2];
      p_s2  <= $signed({1'b0, upper_link_length}) * sn_r[1];
      p_s23 <= $signed({1'b0, lower_link_length}) * sn_r[2];
      c1_2  <= cs_r[0];
      s1_2  <= sn_r[0];
      a_sum <= 36'(p_c2) + 36'(p_c23);
      zs = $signed({5'd0, base_height, 16'd0}) + 37'(p_s2) + 37'(p_s23) + 37'sd32768;
      z_3   <= 21'(zs >>> 16);
      c1_3  <= c1_2;
      s1_3  <= s1_2;
      px    <= c1_3 * a_sum;
      py    <= s1_3 * a_sum;
      z_4   <= z_3;
      xr = 22'((px + 54'sd2147483648) >>> 32);
      yr = 22'((py + 54'sd2147483648) >>> 32);
      pos_x <= clip(xr);
      pos_y <= clip(yr);
      pos_z <= clip(22'(z_4));
    end
  end

endmodule

FILE: src/rrrfk_checker.sv
// ----------------------------------------------------------------------------
// rrrfk_checker
// port-level checks of the forward kinematics core, bound to the top level
// ----------------------------------------------------------------------------
`include "rrr_arm_forward_kinematics_core_assert.svh"
module rrrfk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [18:0] pos_x,
  input logic signed [18:0] pos_y,
  input logic signed [18:0] pos_z
);
  // no output word straight after reset
  `RRRFK_ASSERT_RST(a_empty_after_rst, rst |=> !out_valid)
  // a held output word keeps its value
  `RRRFK_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(pos_x) && $stable(pos_y) && $stable(pos_z))
  // the input only waits behind a held output word
  `RRRFK_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall)
endmodule

bind rrr_arm_forward_kinematics_core rrrfk_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .pos_x    (pos_x),
  .pos_y    (pos_y),
  .pos_z    (pos_z)
);
